[design/sfr_pkg.sv]
package sfr_pkg;

    localparam logic [7:0]  HDR_FIRST     = 8'h55;
    localparam logic [7:0]  HDR_SECOND    = 8'hAA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    localparam logic       FUNC_BYTE = 1'b0;
    localparam logic       FUNC_TICK = 1'b1;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_HEADER   = 3'd1;
    localparam logic [2:0] EV_PAYLOAD  = 3'd2;
    localparam logic [2:0] EV_GOOD     = 3'd3;
    localparam logic [2:0] EV_BADSUM   = 3'd4;
    localparam logic [2:0] EV_SYNCDROP = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;

    localparam logic [2:0] PH_HUNT1    = 3'd0;
    localparam logic [2:0] PH_HUNT2    = 3'd1;
    localparam logic [2:0] PH_VERSION  = 3'd2;
    localparam logic [2:0] PH_COMMAND  = 3'd3;
    localparam logic [2:0] PH_LENHI    = 3'd4;
    localparam logic [2:0] PH_LENLO    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;
    localparam logic [2:0] PH_CHECKSUM = 3'd7;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [7:0]  frame_version;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic [15:0] payload_offset;
    } result_t;

endpackage

[design/sfr_in_if.sv]
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

[design/sfr_out_if.sv]
interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
    logic [15:0] payload_offset;

    modport source (
        output valid, output event_res, output data_byte, output frame_version,
        output frame_command, output frame_length, output payload_offset,
        input ready
    );
    modport sink (
        input valid, input event_res, input data_byte, input frame_version,
        input frame_command, input frame_length, input payload_offset,
        output ready
    );
endinterface

[design/sfr_parser.sv]
module sfr_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            func,
    input  logic [7:0]      rx_byte,
    input  logic [15:0]     timeout,
    output sfr_pkg::result_t result
);
    import sfr_pkg::*;

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] idle_reg,    idle_next;
    logic [15:0] count_inc;
    logic [2:0]  ev;
    logic [7:0]  data;
    logic [15:0] offset;

    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        version_next = version_reg;
        command_next = command_reg;
        idle_next    = idle_reg;
        ev           = EV_NONE;
        data         = 8'd0;
        offset       = 16'd0;

        if (func == FUNC_TICK)
        begin
            if (idle_reg != IDLE_MAX)
            begin
                idle_next = idle_reg + 16'd1;
            end
            if (phase_reg != PH_HUNT1 && idle_next > timeout)
            begin
                phase_next = PH_HUNT1;
                ev         = EV_TIMEOUT;
            end
        end
        else
        begin
            data = rx_byte;
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        // new frame: all frame registers restart
                        sum_next     = HDR_FIRST;
                        version_next = 8'd0;
                        command_next = 8'd0;
                        length_next  = 16'd0;
                        count_next   = 16'd0;
                        idle_next    = 16'd0;
                        phase_next   = PH_HUNT2;
                        ev           = EV_HEADER;
                    end
                end
                PH_HUNT2:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        idle_next  = 16'd0;
                        phase_next = PH_VERSION;
                        ev         = EV_HEADER;
                    end
                    else
                    begin
                        // the offending byte is not retried as a first header byte
                        phase_next = PH_HUNT1;
                        ev         = EV_SYNCDROP;
                    end
                end
                PH_VERSION:
                begin
                    version_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                    idle_next    = 16'd0;
                    phase_next   = PH_COMMAND;
                    ev           = EV_HEADER;
                end
                PH_COMMAND:
                begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                    idle_next    = 16'd0;
                    phase_next   = PH_LENHI;
                    ev           = EV_HEADER;
                end
                PH_LENHI:
                begin
                    length_next = {rx_byte, 8'd0};
                    sum_next    = sum_reg + rx_byte;
                    idle_next   = 16'd0;
                    phase_next  = PH_LENLO;
                    ev          = EV_HEADER;
                end
                PH_LENLO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    sum_next    = sum_reg + rx_byte;
                    idle_next   = 16'd0;
                    count_next  = 16'd0;
                    // empty payload skips straight to the checksum
                    phase_next  = (length_next == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                    ev          = EV_HEADER;
                end
                PH_PAYLOAD:
                begin
                    offset     = count_reg;
                    sum_next   = sum_reg + rx_byte;
                    idle_next  = 16'd0;
                    count_next = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECKSUM;
                    end
                    ev = EV_PAYLOAD;
                end
                PH_CHECKSUM:
                begin
                    ev         = (rx_byte == sum_reg) ? EV_GOOD : EV_BADSUM;
                    phase_next = PH_HUNT1;
                end
            endcase
        end

        result.event_res      = ev;
        result.data_byte      = data;
        result.frame_version  = version_next;
        result.frame_command  = command_next;
        result.frame_length   = length_next;
        result.payload_offset = offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            sum_reg     <= 8'd0;
            length_reg  <= 16'd0;
            count_reg   <= 16'd0;
            version_reg <= 8'd0;
            command_reg <= 8'd0;
            idle_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            version_reg <= version_next;
            command_reg <= command_next;
            idle_reg    <= idle_next;
        end
    end

    a_payload_len_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> length_reg != 16'd0
    ) else $error("payload phase with zero length");

    a_payload_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < length_reg
    ) else $error("payload count ran past length");

    a_frame_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && func == FUNC_BYTE && phase_reg == PH_HUNT1 && rx_byte == HDR_FIRST
        |=> phase_reg == PH_HUNT2 && sum_reg == HDR_FIRST && idle_reg == 16'd0
    ) else $error("frame start did not restart state");

endmodule

[design/sfr_out_reg.sv]
module sfr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t result,
    output logic             can_load,
    sfr_out_if.source        out_ch
);
    import sfr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // a held result is replaced in the same cycle it is taken
    assign can_load = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.event_res      = data_reg.event_res;
    assign out_ch.data_byte      = data_reg.data_byte;
    assign out_ch.frame_version  = data_reg.frame_version;
    assign out_ch.frame_command  = data_reg.frame_command;
    assign out_ch.frame_length   = data_reg.frame_length;
    assign out_ch.payload_offset = data_reg.payload_offset;

endmodule

[design/serial_frame_receiver.sv]
// channel   dir  handshake     payload
// in_ch     in   valid/ready   func, rx_byte
// out_ch    out  valid/ready   event_res, data_byte, frame_version, frame_command,
//                              frame_length, payload_offset
// cfg       in   cfg_we        cfg_wdata (rx_timeout_ticks)
//
// one item per cycle unless stalled; each item yields one result, registered as it is taken
// parser state updates as the item is taken, the result sits in a single output register
// in_ch.ready drops only while a result is held and out_ch.ready is low
// reset clears parser state, empties the output register and loads timeout 300
module serial_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    sfr_in_if.sink      in_ch,
    sfr_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import sfr_pkg::*;

    logic [15:0] timeout_reg;
    logic        can_load;
    logic        step;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = can_load;
    assign step        = in_ch.valid && can_load;

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .func    (in_ch.func),
        .rx_byte (in_ch.rx_byte),
        .timeout (timeout_reg),
        .result  (result)
    );

    sfr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule
